// ===== rtl/core/optimal_rod_cut_cost_assert.svh =====
// ----------------------------------------------------------------------------
// Rod cut cost assertion macros
// Shared concurrent assertion forms for the rod cut cost block.
// ----------------------------------------------------------------------------
`ifndef OPTIMAL_ROD_CUT_COST_ASSERT_SVH
`define OPTIMAL_ROD_CUT_COST_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ORCC_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ORCC_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/orcc_pkg.sv =====
// ----------------------------------------------------------------------------
// Rod cut cost package
// Field widths, the saturation limit and the controller to datapath types.
// ----------------------------------------------------------------------------
package orcc_pkg;

  localparam int POS_W   = 16;
  localparam int COST_W  = 20;
  localparam int SPLIT_W = 5;
  localparam int SUM_W   = 22;

  localparam logic [COST_W-1:0] COST_SAT = '1;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_RD_PJ,
    OP_RD_PI,
    OP_LEN,
    OP_RD_A,
    OP_RD_B,
    OP_ACC,
    OP_CMP,
    OP_WR,
    OP_EMIT
  } op_t;

  typedef struct packed {
    op_t  op;
    logic a_zero;
    logic b_zero;
  } cmd_t;

  typedef struct packed {
    logic ovf;
    logic short_stick;
  } status_t;

endpackage

// ===== rtl/core/orcc_ram.sv =====
// ----------------------------------------------------------------------------
// Rod cut cost RAM
// Generic single write, single read memory with a registered read port.
// ----------------------------------------------------------------------------
module orcc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 17,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/orcc_ctrl.sv =====
// ----------------------------------------------------------------------------
// Rod cut cost controller
// Sequences point loading and the interval table fill over spans and splits.
// ----------------------------------------------------------------------------
module orcc_ctrl #(
  parameter int IW = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic              in_last,
  input  orcc_pkg::status_t status,
  input  logic [IW-1:0]     n,
  output logic              busy,
  output orcc_pkg::cmd_t    cmd,
  output logic [IW-1:0]     idx_i,
  output logic [IW-1:0]     idx_j,
  output logic [IW-1:0]     idx_r
);

  import orcc_pkg::*;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_CHK,
    ST_PJ,
    ST_PI,
    ST_LEN,
    ST_RA,
    ST_RB,
    ST_ACC,
    ST_CMP,
    ST_WR,
    ST_EMIT
  } state_t;

  state_t        state_r, state_nxt;
  logic [IW-1:0] i_r, i_nxt;
  logic [IW-1:0] j_r, j_nxt;
  logic [IW-1:0] r_r, r_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      i_r     <= '0;
      j_r     <= '0;
      r_r     <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      r_r     <= r_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    r_nxt      = r_r;
    cmd.op     = OP_NONE;
    // A one-segment sub-span on either side of the split costs nothing.
    cmd.a_zero = (r_r == i_r + IW'(1));
    cmd.b_zero = (r_r == j_r - IW'(1));
    case (state_r)
      ST_LOAD: begin
        if (accept && in_last) begin
          state_nxt = ST_CHK;
        end
      end
      ST_CHK: begin
        if (status.ovf || status.short_stick) begin
          state_nxt = ST_EMIT;
        end else begin
          j_nxt     = IW'(2);
          i_nxt     = '0;
          state_nxt = ST_PJ;
        end
      end
      ST_PJ: begin
        cmd.op    = OP_RD_PJ;
        state_nxt = ST_PI;
      end
      ST_PI: begin
        cmd.op    = OP_RD_PI;
        state_nxt = ST_LEN;
      end
      ST_LEN: begin
        cmd.op    = OP_LEN;
        r_nxt     = i_r + IW'(1);
        state_nxt = ST_RA;
      end
      ST_RA: begin
        cmd.op    = OP_RD_A;
        state_nxt = ST_RB;
      end
      ST_RB: begin
        cmd.op    = OP_RD_B;
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        cmd.op    = OP_ACC;
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        cmd.op = OP_CMP;
        if (cmd.b_zero) begin
          state_nxt = ST_WR;
        end else begin
          r_nxt     = r_r + IW'(1);
          state_nxt = ST_RA;
        end
      end
      ST_WR: begin
        cmd.op = OP_WR;
        if (i_r == '0) begin
          if (j_r == n) begin
            state_nxt = ST_EMIT;
          end else begin
            // Spans of the next end point start two points below it and walk down.
            j_nxt     = j_r + IW'(1);
            i_nxt     = j_r - IW'(1);
            state_nxt = ST_PJ;
          end
        end else begin
          i_nxt     = i_r - IW'(1);
          state_nxt = ST_PJ;
        end
      end
      ST_EMIT: begin
        cmd.op    = OP_EMIT;
        state_nxt = ST_LOAD;
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  assign busy  = (state_r != ST_LOAD);
  assign idx_i = i_r;
  assign idx_j = j_r;
  assign idx_r = r_r;

endmodule

// ===== rtl/core/orcc_dpath.sv =====
// ----------------------------------------------------------------------------
// Rod cut cost datapath
// Point store, span cost table, split accumulator and result registers.
// ----------------------------------------------------------------------------
module orcc_dpath #(
  parameter int NPTS = 17,
  parameter int IW   = 5,
  parameter int CW   = 5
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic [orcc_pkg::POS_W-1:0]    in_position,
  input  orcc_pkg::cmd_t                cmd,
  input  logic [IW-1:0]                 idx_i,
  input  logic [IW-1:0]                 idx_j,
  input  logic [IW-1:0]                 idx_r,
  output orcc_pkg::status_t             status,
  output logic [IW-1:0]                 n,
  output logic                          out_valid,
  output logic [orcc_pkg::COST_W-1:0]   out_min_cost,
  output logic [orcc_pkg::SPLIT_W-1:0]  out_first_split,
  output logic                          out_overflow
);

  import orcc_pkg::*;

  localparam int AW = $clog2(NPTS * NPTS);

  logic [CW-1:0]      count_r;
  logic               ovf_r;
  logic               out_valid_r;
  logic [COST_W-1:0]  out_cost_r;
  logic [SPLIT_W-1:0] out_split_r;
  logic               out_ovf_r;

  logic [POS_W-1:0]   pj_r;
  logic [POS_W-1:0]   len_r;
  logic [COST_W-1:0]  a_r;
  logic [SUM_W-1:0]   sum_r;
  logic [COST_W-1:0]  best_r;
  logic [IW-1:0]      split_r;

  logic               pt_wr_en;
  logic               pt_rd_en;
  logic [IW-1:0]      pt_rd_addr;
  logic [POS_W-1:0]   pt_rd_data;

  logic               cs_rd_en;
  logic [AW-1:0]      cs_rd_addr;
  logic [COST_W-1:0]  cs_rd_data;
  logic [AW-1:0]      addr_ir;
  logic [AW-1:0]      addr_rj;
  logic [AW-1:0]      addr_ij;

  logic [COST_W-1:0]  b_val;
  logic [COST_W-1:0]  t_val;

  assign pt_wr_en   = accept && (count_r < CW'(NPTS));
  assign pt_rd_en   = (cmd.op == OP_RD_PJ) || (cmd.op == OP_RD_PI);
  assign pt_rd_addr = (cmd.op == OP_RD_PJ) ? idx_j : idx_i;

  orcc_ram #(
    .WIDTH (POS_W),
    .DEPTH (NPTS)
  ) u_points (
    .clk     (clk),
    .wr_en   (pt_wr_en),
    .wr_addr (IW'(count_r)),
    .wr_data (in_position),
    .rd_en   (pt_rd_en),
    .rd_addr (pt_rd_addr),
    .rd_data (pt_rd_data)
  );

  assign addr_ir    = AW'(idx_i) * AW'(NPTS) + AW'(idx_r);
  assign addr_rj    = AW'(idx_r) * AW'(NPTS) + AW'(idx_j);
  assign addr_ij    = AW'(idx_i) * AW'(NPTS) + AW'(idx_j);
  assign cs_rd_en   = (cmd.op == OP_RD_A) || (cmd.op == OP_RD_B);
  assign cs_rd_addr = (cmd.op == OP_RD_A) ? addr_ir : addr_rj;

  orcc_ram #(
    .WIDTH (COST_W),
    .DEPTH (NPTS * NPTS)
  ) u_costs (
    .clk     (clk),
    .wr_en   (cmd.op == OP_WR),
    .wr_addr (addr_ij),
    .wr_data (best_r),
    .rd_en   (cs_rd_en),
    .rd_addr (cs_rd_addr),
    .rd_data (cs_rd_data)
  );

  assign b_val = cmd.b_zero ? '0 : cs_rd_data;
  // Both partial sums saturate, so one clamp of the full sum matches.
  assign t_val = (sum_r > SUM_W'(COST_SAT)) ? COST_SAT : sum_r[COST_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (cmd.op == OP_EMIT);
      if (cmd.op == OP_EMIT) begin
        count_r <= '0;
        ovf_r   <= 1'b0;
      end else if (accept) begin
        if (count_r < CW'(NPTS)) begin
          count_r <= count_r + CW'(1);
        end else begin
          ovf_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_RD_PI: begin
        pj_r <= pt_rd_data;
      end
      OP_LEN: begin
        len_r <= (pj_r >= pt_rd_data) ? (pj_r - pt_rd_data) : '0;
      end
      OP_RD_B: begin
        a_r <= cmd.a_zero ? '0 : cs_rd_data;
      end
      OP_ACC: begin
        sum_r <= SUM_W'(a_r) + SUM_W'(b_val) + SUM_W'(len_r);
      end
      OP_CMP: begin
        // Strict compare keeps the smallest split on ties.
        if (cmd.a_zero || (t_val < best_r)) begin
          best_r  <= t_val;
          split_r <= idx_r;
        end
      end
      OP_EMIT: begin
        if (ovf_r || status.short_stick) begin
          out_cost_r  <= '0;
          out_split_r <= '0;
        end else begin
          out_cost_r  <= best_r;
          out_split_r <= SPLIT_W'(split_r);
        end
        out_ovf_r <= ovf_r;
      end
      default: begin
      end
    endcase
  end

  assign status.ovf         = ovf_r;
  assign status.short_stick = (count_r <= CW'(2));
  assign n                  = IW'(count_r - CW'(1));

  assign out_valid       = out_valid_r;
  assign out_min_cost    = out_cost_r;
  assign out_first_split = out_split_r;
  assign out_overflow    = out_ovf_r;

endmodule

// ===== rtl/core/optimal_rod_cut_cost.sv =====
// ----------------------------------------------------------------------------
// Optimal rod cut cost
// Loads stick end and cut mark positions, then fills the interval cost table
// and reports the least cutting cost and the split taken first.
//
//   Channel  Ports                                    Handshake
//   input    in_position, in_last                     start high, busy low
//   result   out_min_cost, out_first_split,           out_valid, one cycle
//            out_overflow
//
// Each point beat is taken while start is high and busy is low. After the beat
// marked last the block stays busy: a check state, then, for n = points - 1 >= 2
// and no overflow, a table fill over spans of L = 2..n segments, then an emit
// state. Each split reads the cost table twice, once per sub-span, on one port.
// Reset clears the point count and overflow flag; the tables need no clearing.
// The result beat cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
`include "optimal_rod_cut_cost_assert.svh"

module optimal_rod_cut_cost #(
  parameter int MAX_SEGMENTS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [orcc_pkg::POS_W-1:0]    in_position,
  input  logic                          in_last,
  output logic                          out_valid,
  output logic [orcc_pkg::COST_W-1:0]   out_min_cost,
  output logic [orcc_pkg::SPLIT_W-1:0]  out_first_split,
  output logic                          out_overflow
);

  import orcc_pkg::*;

  localparam int NPTS = MAX_SEGMENTS + 1;
  localparam int IW   = $clog2(NPTS);
  localparam int CW   = $clog2(NPTS + 1);

  logic          accept;
  cmd_t          cmd;
  status_t       status;
  logic [IW-1:0] n;
  logic [IW-1:0] idx_i;
  logic [IW-1:0] idx_j;
  logic [IW-1:0] idx_r;

  assign accept = start && !busy;

  orcc_ctrl #(
    .IW (IW)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_last (in_last),
    .status  (status),
    .n       (n),
    .busy    (busy),
    .cmd     (cmd),
    .idx_i   (idx_i),
    .idx_j   (idx_j),
    .idx_r   (idx_r)
  );

  orcc_dpath #(
    .NPTS (NPTS),
    .IW   (IW),
    .CW   (CW)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (accept),
    .in_position     (in_position),
    .cmd             (cmd),
    .idx_i           (idx_i),
    .idx_j           (idx_j),
    .idx_r           (idx_r),
    .status          (status),
    .n               (n),
    .out_valid       (out_valid),
    .out_min_cost    (out_min_cost),
    .out_first_split (out_first_split),
    .out_overflow    (out_overflow)
  );

  `ORCC_ASSERT_NXT(a_last_busy, clk, rst_n, accept && in_last, busy, "no solve after last beat")
  `ORCC_ASSERT_IMP(a_valid_idle, clk, rst_n, out_valid, !busy, "result while still busy")
  `ORCC_ASSERT_NXT(a_valid_pulse, clk, rst_n, out_valid, !out_valid, "result beat repeated")
  `ORCC_ASSERT_IMP(a_ovf_zero, clk, rst_n, out_valid && out_overflow,
                   (out_min_cost == '0) && (out_first_split == '0), "overflow with a cost")

endmodule
